[sv/mbsp_pkg.sv]
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types and constants of the MIDI byte stream message parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

    localparam int RX_BYTE_W     = 8;
    localparam int RATE_W        = 21;
    localparam int DATA_W        = 7;
    localparam int LEN_W         = 2;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam int SYSEX_MAX_LEN = 256;
    localparam int SYSEX_CNT_W   = $clog2(SYSEX_MAX_LEN);

    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RATE_W-1:0] RATE_MIN_RESET = RATE_W'(29687);
    localparam logic [RATE_W-1:0] RATE_MAX_RESET = RATE_W'(32812);

    localparam logic REG_RATE_MIN = 1'b0;
    localparam logic REG_RATE_MAX = 1'b1;

    localparam logic [7:0] ST_VOICE_LO   = 8'h80;
    localparam logic [7:0] ST_PROG_CHG   = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_QFRAME     = 8'hF1;
    localparam logic [7:0] ST_SONG_POS   = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL   = 8'hF3;
    localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;
    localparam logic [7:0] ST_EOX        = 8'hF7;
    localparam logic [7:0] ST_REALTIME   = 8'hF8;
    localparam logic [7:0] ST_RT_UNDEF_A = 8'hF9;
    localparam logic [7:0] ST_RT_UNDEF_B = 8'hFD;

    localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

    typedef enum logic [2:0] {
        K_REJECT   = 3'd0,
        K_REALTIME = 3'd1,
        K_DATA     = 3'd2,
        K_STATUS   = 3'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [RX_BYTE_W-1:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic [RATE_W-1:0] rate_min;
        logic [RATE_W-1:0] rate_max;
    } t_rate_cfg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_D1OF2  = 4'b0010,
        PH_D2OF2  = 4'b0100,
        PH_D1OF1  = 4'b1000
    } t_phase;

endpackage

[sv/mbsp_front.sv]
// ----------------------------------------------------------------------------
// mbsp_front
// Rate window registers and per-byte classification into queue commands.
// ----------------------------------------------------------------------------
module mbsp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mbsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mbsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mbsp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               i_valid,
    input  logic                               i_queue_full,
    input  logic [mbsp_pkg::RX_BYTE_W-1:0]     i_rx_byte,
    input  logic [mbsp_pkg::RATE_W-1:0]        i_bit_rate,
    output logic                               o_stall,
    output logic                               o_push,
    output mbsp_pkg::t_cmd                     o_cmd
);

    mbsp_pkg::t_rate_cfg r_cfg;
    logic                cfg_wr;
    logic                reg_sel;
    logic                rate_bad;
    logic                rt_undef;
    logic                accept;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_min <= mbsp_pkg::RATE_MIN_RESET;
            r_cfg.rate_max <= mbsp_pkg::RATE_MAX_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == mbsp_pkg::REG_RATE_MIN) begin
                r_cfg.rate_min <= pwdata[mbsp_pkg::RATE_W-1:0];
            end else begin
                r_cfg.rate_max <= pwdata[mbsp_pkg::RATE_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == mbsp_pkg::REG_RATE_MIN) begin
            prdata = mbsp_pkg::APB_DATA_W'(r_cfg.rate_min);
        end else begin
            prdata = mbsp_pkg::APB_DATA_W'(r_cfg.rate_max);
        end
    end

    assign o_stall  = i_queue_full;
    assign accept   = i_valid && !i_queue_full;
    assign rate_bad = (i_bit_rate < r_cfg.rate_min) || (i_bit_rate > r_cfg.rate_max);
    assign rt_undef = (i_rx_byte == mbsp_pkg::ST_RT_UNDEF_A) ||
                      (i_rx_byte == mbsp_pkg::ST_RT_UNDEF_B);

    always_comb begin
        o_cmd.rx_byte = i_rx_byte;
        o_push        = accept;
        if (rate_bad) begin
            o_cmd.kind = mbsp_pkg::K_REJECT;
        end else if (i_rx_byte >= mbsp_pkg::ST_REALTIME) begin
            o_cmd.kind = mbsp_pkg::K_REALTIME;
            // drop undefined real-time codes here
            o_push     = accept && !rt_undef;
        end else if (i_rx_byte < mbsp_pkg::ST_VOICE_LO) begin
            o_cmd.kind = mbsp_pkg::K_DATA;
        end else begin
            o_cmd.kind = mbsp_pkg::K_STATUS;
        end
    end

endmodule

[sv/mbsp_queue.sv]
// ----------------------------------------------------------------------------
// mbsp_queue
// Short command queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module mbsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbsp_pkg::t_cmd i_push_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output mbsp_pkg::t_cmd o_pop_cmd
);

    mbsp_pkg::t_cmd                    r_mem [mbsp_pkg::QUEUE_DEPTH];
    logic [mbsp_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [mbsp_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [mbsp_pkg::QUEUE_CNT_W-1:0]  r_count;
    logic [mbsp_pkg::QUEUE_CNT_W-1:0]  n_count;
    logic                              do_pop;

    assign o_full     = (r_count == mbsp_pkg::QUEUE_CNT_W'(mbsp_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_pop_cmd  = r_mem[r_rd_ptr];
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

[sv/mbsp_back.sv]
// ----------------------------------------------------------------------------
// mbsp_back
// Running status parser state and registered message output.
// ----------------------------------------------------------------------------
module mbsp_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  mbsp_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [mbsp_pkg::RX_BYTE_W-1:0]   o_msg_status,
    output logic [mbsp_pkg::DATA_W-1:0]      o_msg_data1,
    output logic [mbsp_pkg::DATA_W-1:0]      o_msg_data2,
    output logic [mbsp_pkg::LEN_W-1:0]       o_msg_length
);

    mbsp_pkg::t_phase                    r_phase;
    mbsp_pkg::t_phase                    n_phase;
    logic                                r_in_sysex;
    logic                                n_in_sysex;
    logic [7:0]                          r_last_status;
    logic [7:0]                          n_last_status;
    logic [mbsp_pkg::DATA_W-1:0]         r_held_data1;
    logic [mbsp_pkg::DATA_W-1:0]         n_held_data1;
    logic [mbsp_pkg::SYSEX_CNT_W-1:0]    r_sysex_count;
    logic [mbsp_pkg::SYSEX_CNT_W-1:0]    n_sysex_count;
    logic                                r_out_valid;
    logic [7:0]                          r_out_status;
    logic [mbsp_pkg::DATA_W-1:0]         r_out_data1;
    logic [mbsp_pkg::DATA_W-1:0]         r_out_data2;
    logic [mbsp_pkg::LEN_W-1:0]          r_out_length;

    logic                                emit;
    logic [7:0]                          emit_status;
    logic [mbsp_pkg::DATA_W-1:0]         emit_data1;
    logic [mbsp_pkg::DATA_W-1:0]         emit_data2;
    logic [mbsp_pkg::LEN_W-1:0]          emit_length;

    logic [7:0]                          c;
    logic [mbsp_pkg::DATA_W-1:0]         c7;
    logic                                last_is_voice;
    logic                                last_one_data;
    logic                                c_one_data;

    assign o_pop = i_cmd_valid && (!r_out_valid || !i_stall);

    assign c  = i_cmd.rx_byte;
    assign c7 = c[mbsp_pkg::DATA_W-1:0];
    assign last_is_voice = (r_last_status >= mbsp_pkg::ST_VOICE_LO) &&
                           (r_last_status < mbsp_pkg::ST_SYSEX);
    assign last_one_data = ({r_last_status[7:4], 4'h0} == mbsp_pkg::ST_PROG_CHG) ||
                           ({r_last_status[7:4], 4'h0} == mbsp_pkg::ST_CHAN_PRESS);
    assign c_one_data    = ({c[7:4], 4'h0} == mbsp_pkg::ST_PROG_CHG) ||
                           ({c[7:4], 4'h0} == mbsp_pkg::ST_CHAN_PRESS);

    always_comb begin
        n_phase       = r_phase;
        n_in_sysex    = r_in_sysex;
        n_last_status = r_last_status;
        n_held_data1  = r_held_data1;
        n_sysex_count = r_sysex_count;
        emit          = 1'b0;
        emit_status   = c;
        emit_data1    = '0;
        emit_data2    = '0;
        emit_length   = mbsp_pkg::LEN_ONE;

        case (i_cmd.kind)
            mbsp_pkg::K_REJECT: begin
                n_phase = mbsp_pkg::PH_IDLE;
            end
            mbsp_pkg::K_REALTIME: begin
                emit = 1'b1;
            end
            mbsp_pkg::K_DATA: begin
                if (r_phase != mbsp_pkg::PH_IDLE) begin
                    emit_status = r_last_status;
                    case (r_phase)
                        mbsp_pkg::PH_D1OF2: begin
                            n_held_data1 = c7;
                            n_phase      = mbsp_pkg::PH_D2OF2;
                        end
                        mbsp_pkg::PH_D2OF2: begin
                            n_phase     = mbsp_pkg::PH_IDLE;
                            emit        = 1'b1;
                            emit_data1  = r_held_data1;
                            emit_data2  = c7;
                            emit_length = mbsp_pkg::LEN_THREE;
                        end
                        default: begin
                            n_phase     = mbsp_pkg::PH_IDLE;
                            emit        = 1'b1;
                            emit_data1  = c7;
                            emit_length = mbsp_pkg::LEN_TWO;
                        end
                    endcase
                end else if (r_in_sysex) begin
                    if (r_sysex_count == mbsp_pkg::SYSEX_CNT_W'(mbsp_pkg::SYSEX_MAX_LEN - 1)) begin
                        n_in_sysex    = 1'b0;
                        n_sysex_count = '0;
                    end else begin
                        n_sysex_count = r_sysex_count + 1'b1;
                    end
                end else if (last_is_voice) begin
                    emit_status = r_last_status;
                    if (last_one_data) begin
                        emit        = 1'b1;
                        emit_data1  = c7;
                        emit_length = mbsp_pkg::LEN_TWO;
                    end else begin
                        n_held_data1 = c7;
                        n_phase      = mbsp_pkg::PH_D2OF2;
                    end
                end
            end
            mbsp_pkg::K_STATUS: begin
                n_phase = mbsp_pkg::PH_IDLE;
                if (r_in_sysex) begin
                    if (c == mbsp_pkg::ST_EOX) begin
                        n_in_sysex    = 1'b0;
                        n_sysex_count = '0;
                    end
                end else begin
                    n_last_status = c;
                    if (c < mbsp_pkg::ST_SYSEX) begin
                        n_phase = c_one_data ? mbsp_pkg::PH_D1OF1 : mbsp_pkg::PH_D1OF2;
                    end else begin
                        case (c)
                            mbsp_pkg::ST_SYSEX: begin
                                n_in_sysex    = 1'b1;
                                n_sysex_count = '0;
                            end
                            mbsp_pkg::ST_QFRAME,
                            mbsp_pkg::ST_SONG_SEL: begin
                                n_phase = mbsp_pkg::PH_D1OF1;
                            end
                            mbsp_pkg::ST_SONG_POS: begin
                                n_phase = mbsp_pkg::PH_D1OF2;
                            end
                            mbsp_pkg::ST_TUNE_REQ: begin
                                emit = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= mbsp_pkg::PH_IDLE;
            r_in_sysex    <= 1'b0;
            r_last_status <= '0;
            r_held_data1  <= '0;
            r_sysex_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase       <= n_phase;
                r_in_sysex    <= n_in_sysex;
                r_last_status <= n_last_status;
                r_held_data1  <= n_held_data1;
                r_sysex_count <= n_sysex_count;
                r_out_valid   <= emit;
            end else if (!i_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_status <= emit_status;
            r_out_data1  <= emit_data1;
            r_out_data2  <= emit_data2;
            r_out_length <= emit_length;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_msg_status = r_out_status;
    assign o_msg_data1  = r_out_data1;
    assign o_msg_data2  = r_out_data2;
    assign o_msg_length = r_out_length;

endmodule

[sv/midi_byte_stream_message_parser_unit.sv]
// ----------------------------------------------------------------------------
// midi_byte_stream_message_parser_unit
// MIDI byte stream parser with running status and a bit rate window.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte) with
// its measured bit rate (i_bit_rate) per beat. Output channel: o_valid /
// i_stall carry one complete message per beat (status, two data bytes,
// length 1 to 3). Bytes outside the rate window, data bytes of a message
// still in progress and SysEx content produce no beat.
// A byte enters the classifier and a two-entry command queue, and the
// parser takes one command per cycle into a registered output unless a
// message held there is stalled; a message passes the queue, then that register.
// Throughput is one byte per cycle unless the output stalls; the parser's
// single-entry output register sets it, and the queue covers such a stall.
// While a stalled message is held, the queue fills and then o_stall rises.
// Reset (i_rst_n low at a clock edge) empties the queue and the output,
// clears the parse state and loads the default rate window 29687..32812.
// The window registers sit on the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module midi_byte_stream_message_parser_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbsp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mbsp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mbsp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [mbsp_pkg::RX_BYTE_W-1:0]   i_rx_byte,
    input  logic [mbsp_pkg::RATE_W-1:0]      i_bit_rate,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [mbsp_pkg::RX_BYTE_W-1:0]   o_msg_status,
    output logic [mbsp_pkg::DATA_W-1:0]      o_msg_data1,
    output logic [mbsp_pkg::DATA_W-1:0]      o_msg_data2,
    output logic [mbsp_pkg::LEN_W-1:0]       o_msg_length
);

    logic           queue_full;
    logic           queue_nonempty;
    logic           push;
    logic           pop;
    mbsp_pkg::t_cmd push_cmd;
    mbsp_pkg::t_cmd pop_cmd;

    mbsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .i_queue_full (queue_full),
        .i_rx_byte    (i_rx_byte),
        .i_bit_rate   (i_bit_rate),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    mbsp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_nonempty (queue_nonempty),
        .o_pop_cmd  (pop_cmd)
    );

    mbsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (queue_nonempty),
        .i_cmd        (pop_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_msg_status (o_msg_status),
        .o_msg_data1  (o_msg_data1),
        .o_msg_data2  (o_msg_data2),
        .o_msg_length (o_msg_length)
    );

endmodule

[bench/midi_byte_stream_message_parser_unit_test.sv]
// ----------------------------------------------------------------------------
// midi_byte_stream_message_parser_unit_test
// Self-checking bench for the MIDI byte stream message parser. Bytes with
// measured bit rates go in on the input channel. A behavioral parser follows
// each accepted beat and queues the message it should produce, and every
// output beat is compared field by field with the oldest queued message.
// The run covers directed corner cases, random well-formed and broken traffic,
// a SysEx overflow, a long output stall and several bit rate windows set over
// the APB port.
// ----------------------------------------------------------------------------
module midi_byte_stream_message_parser_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 8;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 21;

    typedef logic [mbsp_pkg::RATE_W-1:0] t_rate;

    localparam t_rate RATE_HI      = t_rate'(2000000);
    localparam t_rate NOMINAL_RATE = t_rate'(31250);

    localparam logic [7:0] ST_NOTE_ON    = 8'h90;
    localparam logic [7:0] ST_POLY_PRESS = 8'hA0;
    localparam logic [7:0] ST_PITCH_BEND = 8'hE0;
    localparam logic [7:0] ST_UNDEF_F4   = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5   = 8'hF5;
    localparam logic [7:0] ST_RESET      = 8'hFF;
    localparam logic [7:0] ST_VOICE_HI   = 8'hEF;

    typedef struct packed {
        logic [mbsp_pkg::RX_BYTE_W-1:0] status;
        logic [mbsp_pkg::DATA_W-1:0]    data1;
        logic [mbsp_pkg::DATA_W-1:0]    data2;
        logic [mbsp_pkg::LEN_W-1:0]     len;
    } t_msg;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mbsp_pkg::APB_ADDR_W-1:0] paddr;
    logic [mbsp_pkg::APB_DATA_W-1:0] pwdata;
    logic [mbsp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            i_valid;
    logic                            o_stall;
    logic [mbsp_pkg::RX_BYTE_W-1:0]  i_rx_byte;
    logic [mbsp_pkg::RATE_W-1:0]     i_bit_rate;
    logic                            o_valid;
    logic                            i_stall;
    logic [mbsp_pkg::RX_BYTE_W-1:0]  o_msg_status;
    logic [mbsp_pkg::DATA_W-1:0]     o_msg_data1;
    logic [mbsp_pkg::DATA_W-1:0]     o_msg_data2;
    logic [mbsp_pkg::LEN_W-1:0]      o_msg_length;

    midi_byte_stream_message_parser_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_bit_rate   (i_bit_rate),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_msg_status (o_msg_status),
        .o_msg_data1  (o_msg_data1),
        .o_msg_data2  (o_msg_data2),
        .o_msg_length (o_msg_length)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // behavioral parser state and window
    t_rate             win_min     = mbsp_pkg::RATE_MIN_RESET;
    t_rate             win_max     = mbsp_pkg::RATE_MAX_RESET;
    mbsp_pkg::t_phase  parse_phase = mbsp_pkg::PH_IDLE;
    bit                sysex_open  = 1'b0;
    logic [7:0]        last_st     = 8'h00;
    logic [6:0]        held_d1     = 7'h00;
    int                sysex_len   = 0;

    t_msg           pending_msgs [$];
    int             mismatches   = 0;
    int             bytes_sent   = 0;
    int             msgs_checked = 0;
    int             stall_cycles = 0;
    int             cycle_count  = 0;
    int             windows_run  = 0;
    int             hold_cycles  = 0;
    bit             idling_on    = 1'b1;

    function automatic mbsp_pkg::t_phase first_phase(input logic [7:0] st);
        logic [7:0] hi;
        hi = st & 8'hF0;
        if (hi == mbsp_pkg::ST_PROG_CHG || hi == mbsp_pkg::ST_CHAN_PRESS)
            return mbsp_pkg::PH_D1OF1;
        return mbsp_pkg::PH_D1OF2;
    endfunction

    function automatic bit take_data(input logic [6:0] d, output t_msg m);
        m = '0;
        case (parse_phase)
            mbsp_pkg::PH_D1OF2: begin
                held_d1     = d;
                parse_phase = mbsp_pkg::PH_D2OF2;
            end
            mbsp_pkg::PH_D2OF2: begin
                parse_phase = mbsp_pkg::PH_IDLE;
                m = '{status: last_st, data1: held_d1, data2: d, len: mbsp_pkg::LEN_THREE};
                return 1'b1;
            end
            mbsp_pkg::PH_D1OF1: begin
                parse_phase = mbsp_pkg::PH_IDLE;
                m = '{status: last_st, data1: d, data2: 7'd0, len: mbsp_pkg::LEN_TWO};
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, input t_rate rate, output t_msg m);
        bit hit;
        hit = 1'b0;
        m   = '0;
        if (rate < win_min || rate > win_max) begin
            parse_phase = mbsp_pkg::PH_IDLE;
        end else if (c >= mbsp_pkg::ST_REALTIME) begin
            if (c != mbsp_pkg::ST_RT_UNDEF_A && c != mbsp_pkg::ST_RT_UNDEF_B) begin
                m   = '{status: c, data1: 7'd0, data2: 7'd0, len: mbsp_pkg::LEN_ONE};
                hit = 1'b1;
            end
        end else if (parse_phase != mbsp_pkg::PH_IDLE && c < mbsp_pkg::ST_VOICE_LO) begin
            hit = take_data(c[6:0], m);
        end else begin
            parse_phase = mbsp_pkg::PH_IDLE;
            if (sysex_open) begin
                if (c == mbsp_pkg::ST_EOX) begin
                    sysex_open = 1'b0;
                    sysex_len  = 0;
                end else if (c < mbsp_pkg::ST_VOICE_LO) begin
                    sysex_len++;
                    if (sysex_len >= mbsp_pkg::SYSEX_MAX_LEN) begin
                        sysex_open = 1'b0;
                        sysex_len  = 0;
                    end
                end
            end else if (c < mbsp_pkg::ST_VOICE_LO) begin
                if (last_st >= mbsp_pkg::ST_VOICE_LO && last_st < mbsp_pkg::ST_SYSEX) begin
                    parse_phase = first_phase(last_st);
                    hit = take_data(c[6:0], m);
                end
            end else begin
                last_st = c;
                if (c < mbsp_pkg::ST_SYSEX) begin
                    parse_phase = first_phase(c);
                end else begin
                    case (c)
                        mbsp_pkg::ST_SYSEX: begin
                            sysex_open = 1'b1;
                            sysex_len  = 0;
                        end
                        mbsp_pkg::ST_QFRAME, mbsp_pkg::ST_SONG_SEL:
                            parse_phase = mbsp_pkg::PH_D1OF1;
                        mbsp_pkg::ST_SONG_POS: parse_phase = mbsp_pkg::PH_D1OF2;
                        mbsp_pkg::ST_TUNE_REQ: begin
                            m   = '{status: c, data1: 7'd0, data2: 7'd0,
                                    len: mbsp_pkg::LEN_ONE};
                            hit = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_msg want;
        if (i_rst_n && i_valid && o_stall)
            stall_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_msgs.size() == 0) begin
                report_mismatch("message with none pending", 32'(o_msg_status), '0);
            end else begin
                want = pending_msgs.pop_front();
                msgs_checked++;
                if (o_msg_status !== want.status)
                    report_mismatch("msg_status", 32'(o_msg_status), 32'(want.status));
                if (o_msg_data1 !== want.data1)
                    report_mismatch("msg_data1", 32'(o_msg_data1), 32'(want.data1));
                if (o_msg_data2 !== want.data2)
                    report_mismatch("msg_data2", 32'(o_msg_data2), 32'(want.data2));
                if (o_msg_length !== want.len)
                    report_mismatch("msg_length", 32'(o_msg_length), 32'(want.len));
            end
        end
    end

    // output stall: long hold-off on request, else random while idling_on is set
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d messages pending",
                     cycle_count, pending_msgs.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] rx, input t_rate rate);
        t_msg m;
        while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_rx_byte  <= rx;
        i_bit_rate <= rate;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        if (parse_byte(rx, rate, m))
            pending_msgs.push_back(m);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input t_rate value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= mbsp_pkg::APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mbsp_pkg::REG_RATE_MIN)
            win_min = value;
        else
            win_max = value;
    endtask

    task automatic apb_check(input logic idx, input t_rate want);
        logic [mbsp_pkg::APB_DATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== mbsp_pkg::APB_DATA_W'(want))
            report_mismatch(idx == mbsp_pkg::REG_RATE_MIN ? "rate_min readback"
                                                          : "rate_max readback",
                            got, mbsp_pkg::APB_DATA_W'(want));
    endtask

    task automatic set_window(input t_rate lo, input t_rate hi);
        apb_write(mbsp_pkg::REG_RATE_MIN, lo);
        apb_write(mbsp_pkg::REG_RATE_MAX, hi);
        apb_check(mbsp_pkg::REG_RATE_MIN, lo);
        apb_check(mbsp_pkg::REG_RATE_MAX, hi);
    endtask

    function automatic t_rate pick_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return t_rate'($urandom_range(win_min, win_max));
        if (r < 92 && win_min > 0)
            return win_min - 1'b1;
        if (r < 96 && win_max < RATE_HI)
            return win_max + 1'b1;
        return t_rate'($urandom_range(0, RATE_HI));
    endfunction

    function automatic int data_count(input logic [7:0] st);
        if (st < mbsp_pkg::ST_SYSEX)
            return (first_phase(st) == mbsp_pkg::PH_D1OF1) ? 1 : 2;
        if (st == mbsp_pkg::ST_QFRAME || st == mbsp_pkg::ST_SONG_SEL)
            return 1;
        if (st == mbsp_pkg::ST_SONG_POS)
            return 2;
        return 0;
    endfunction

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic send_mixed(input logic [7:0] rx);
        if ($urandom_range(0, 99) < 6)
            send_byte(8'($urandom_range(mbsp_pkg::ST_REALTIME, ST_RESET)), pick_rate());
        send_byte(rx, pick_rate());
    endtask

    task automatic send_random_message();
        int         pick;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            st = 8'($urandom_range(mbsp_pkg::ST_VOICE_LO, ST_VOICE_HI));
            send_mixed(st);
            repeat (data_count(st)) send_mixed(rand_data());
        end else if (pick < 58) begin
            repeat ($urandom_range(1, 2)) send_mixed(rand_data());
        end else if (pick < 70) begin
            case ($urandom_range(0, 6))
                0: st = mbsp_pkg::ST_QFRAME;
                1: st = mbsp_pkg::ST_SONG_POS;
                2: st = mbsp_pkg::ST_SONG_SEL;
                3: st = mbsp_pkg::ST_TUNE_REQ;
                4: st = ST_UNDEF_F4;
                5: st = ST_UNDEF_F5;
                default: st = mbsp_pkg::ST_EOX;
            endcase
            send_mixed(st);
            repeat (data_count(st)) send_mixed(rand_data());
        end else if (pick < 78) begin
            send_mixed(mbsp_pkg::ST_SYSEX);
            repeat ($urandom_range(0, 10)) begin
                if ($urandom_range(0, 99) < 10)
                    send_mixed(8'($urandom_range(mbsp_pkg::ST_VOICE_LO, mbsp_pkg::ST_EOX)));
                else
                    send_mixed(rand_data());
            end
            if ($urandom_range(0, 99) < 80)
                send_mixed(mbsp_pkg::ST_EOX);
        end else if (pick < 86) begin
            // cut short by a new status
            st = 8'($urandom_range(mbsp_pkg::ST_VOICE_LO, ST_VOICE_HI));
            send_mixed(st);
            if (data_count(st) == 2)
                send_mixed(rand_data());
            send_mixed(8'($urandom_range(mbsp_pkg::ST_VOICE_LO, ST_RESET)));
        end else begin
            send_mixed(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target) send_random_message();
    endtask

    task automatic test_register_access();
        apb_check(mbsp_pkg::REG_RATE_MIN, mbsp_pkg::RATE_MIN_RESET);
        apb_check(mbsp_pkg::REG_RATE_MAX, mbsp_pkg::RATE_MAX_RESET);
        set_window(t_rate'($urandom_range(0, RATE_HI)), t_rate'($urandom_range(0, RATE_HI)));
        set_window(mbsp_pkg::RATE_MIN_RESET, mbsp_pkg::RATE_MAX_RESET);
    endtask

    task automatic test_directed();
        send_byte(8'h40, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_RT_UNDEF_A, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_RT_UNDEF_B, NOMINAL_RATE);
        send_byte(ST_NOTE_ON, mbsp_pkg::RATE_MIN_RESET);
        send_byte(8'h3C, mbsp_pkg::RATE_MAX_RESET);
        send_byte(8'h7F, NOMINAL_RATE);
        send_byte(8'h00, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_REALTIME, NOMINAL_RATE);
        send_byte(8'h00, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_PROG_CHG | 8'h05, NOMINAL_RATE);
        send_byte(8'h12, NOMINAL_RATE);
        send_byte(ST_POLY_PRESS, NOMINAL_RATE);
        send_byte(8'h10, NOMINAL_RATE);
        send_byte(ST_PITCH_BEND, NOMINAL_RATE);
        send_byte(8'h20, NOMINAL_RATE);
        send_byte(8'h21, mbsp_pkg::RATE_MAX_RESET + 1'b1);
        send_byte(8'h30, NOMINAL_RATE);
        send_byte(8'h7F, NOMINAL_RATE);
        send_byte(ST_RESET, RATE_HI);
        send_byte(ST_RESET, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_QFRAME, NOMINAL_RATE);
        send_byte(8'h55, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_SONG_POS, NOMINAL_RATE);
        send_byte(8'h01, NOMINAL_RATE);
        send_byte(8'h7F, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_TUNE_REQ, NOMINAL_RATE);
        send_byte(ST_UNDEF_F4, NOMINAL_RATE);
        send_byte(8'h10, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_SYSEX, NOMINAL_RATE);
        send_byte(8'h11, mbsp_pkg::RATE_MIN_RESET - 1'b1);
        send_byte(ST_NOTE_ON, NOMINAL_RATE);
        send_byte(8'h12, '0);
        send_byte(mbsp_pkg::ST_EOX, NOMINAL_RATE);
        send_byte(mbsp_pkg::ST_EOX, NOMINAL_RATE);
    endtask

    task automatic test_random_stream();
        idling_on = 1'b0;
        run_random(60);
        idling_on = 1'b1;
        run_random(80);
    endtask

    task automatic test_sysex_overflow();
        send_byte(mbsp_pkg::ST_SYSEX, NOMINAL_RATE);
        while (sysex_open) send_mixed(rand_data());
        repeat (3) send_mixed(rand_data());
        send_mixed(mbsp_pkg::ST_CHAN_PRESS);
        send_mixed(rand_data());
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 150;
        repeat (24) send_byte(8'($urandom_range(mbsp_pkg::ST_REALTIME, ST_RESET)), NOMINAL_RATE);
        wait_idle();
    endtask

    task automatic test_rate_windows();
        t_rate lo;
        t_rate hi;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin lo = '0;      hi = '0;      end
                1: begin lo = RATE_HI; hi = RATE_HI; end
                2: begin lo = '0;      hi = RATE_HI; end
                3: begin
                    lo = t_rate'($urandom_range(1000, RATE_HI));
                    hi = t_rate'($urandom_range(0, lo - 1));
                end
                4: begin
                    lo = t_rate'($urandom_range(0, RATE_HI - 5000));
                    hi = lo + t_rate'($urandom_range(0, 5000));
                end
                default: begin
                    lo = mbsp_pkg::RATE_MIN_RESET;
                    hi = mbsp_pkg::RATE_MAX_RESET;
                end
            endcase
            wait_idle();
            set_window(lo, hi);
            windows_run++;
            run_random(40);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_rx_byte  = '0;
        i_bit_rate = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_directed();
        test_random_stream();
        test_sysex_overflow();
        test_output_backpressure();
        test_rate_windows();
        wait_idle();

        $display("%0d bytes sent, %0d messages checked, %0d rate windows tried",
                 bytes_sent, msgs_checked, windows_run);
        $display("input held off for %0d cycles, %0d mismatches", stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
